// ----- src/ole_pkg.sv -----
// ----------------------------------------------------------------------------
// ole_pkg: shared types and constants of the ordered item list engine
// Sizes, action and status codes, cell commands and the control structs that
// the controller hands to every cell of the chain.
// ----------------------------------------------------------------------------
package ole_pkg;

   localparam int DEPTH  = 64;
   localparam int ITEM_W = 32;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ACT_W  = 4;
   localparam int POS_W  = 7;
   localparam int STAT_W = 2;

   // match bits are reduced in groups of eight before the final pick
   localparam int GRP    = 8;
   localparam int GRP_W  = $clog2(GRP);
   localparam int NGRP   = (DEPTH + GRP - 1) / GRP;

   localparam int REQ_W  = ((ACT_W + 2 * POS_W + ITEM_W + 7) / 8) * 8;
   localparam int RSP_W  = ((POS_W + ITEM_W + STAT_W + CNT_W + 7) / 8) * 8;

   typedef enum logic [ACT_W-1:0] {
      ACT_APPEND   = 4'd0,
      ACT_INSERT   = 4'd1,
      ACT_DELETE   = 4'd2,
      ACT_EXCHANGE = 4'd3,
      ACT_SEARCH   = 4'd4,
      ACT_REMOVE   = 4'd5,
      ACT_CLEAR    = 4'd6,
      ACT_FIRST    = 4'd7,
      ACT_LAST     = 4'd8
   } ole_action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_BAD  = 2'd1,
      STAT_FULL = 2'd2,
      STAT_MISS = 2'd3
   } ole_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_GROUP,
      ST_EXEC
   } ole_state_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_WRITE,
      CMD_INSERT,
      CMD_DROP,
      CMD_SWAP
   } ole_cmd_kind_type;

   // broadcast to every cell: what to compare and which entries to read
   typedef struct packed {
      logic [ITEM_W-1:0] key;
      logic [CNT_W-1:0]  count;
      logic [IDX_W-1:0]  sel_a;
      logic [IDX_W-1:0]  sel_b;
   } ole_look_type;

   // broadcast to every cell: how to update the entry
   typedef struct packed {
      ole_cmd_kind_type  kind;
      logic [IDX_W-1:0]  pos_a;
      logic [IDX_W-1:0]  pos_b;
      logic [ITEM_W-1:0] wvalue;
      logic [ITEM_W-1:0] data_a;
      logic [ITEM_W-1:0] data_b;
   } ole_cmd_type;

endpackage

// ----- src/ole_cell.sv -----
// ----------------------------------------------------------------------------
// ole_cell: one entry of the list chain
// Holds one word, takes its neighbour's word on insert or delete, compares
// against the search key and drives the read buses when selected.
// ----------------------------------------------------------------------------
module ole_cell (
   input  logic                      clock,
   input  logic [ole_pkg::IDX_W-1:0]  cell_pos,
   input  ole_pkg::ole_look_type      look,
   input  ole_pkg::ole_cmd_type       cmd,
   input  logic [ole_pkg::ITEM_W-1:0] left_entry,
   input  logic [ole_pkg::ITEM_W-1:0] right_entry,
   output logic [ole_pkg::ITEM_W-1:0] entry,
   output logic                      hit,
   output logic [ole_pkg::ITEM_W-1:0] rd_a,
   output logic [ole_pkg::ITEM_W-1:0] rd_b
);
   import ole_pkg::*;

   logic [ITEM_W-1:0] entry_ff, entry_in;
   logic              hit_ff, hit_in;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.kind)
         CMD_WRITE: begin
            if (cell_pos == cmd.pos_a) entry_in = cmd.wvalue;
         end
         CMD_INSERT: begin
            if (cell_pos == cmd.pos_a) entry_in = cmd.wvalue;
            else if (cell_pos > cmd.pos_a) entry_in = left_entry;
         end
         CMD_DROP: begin
            if (cell_pos >= cmd.pos_a) entry_in = right_entry;
         end
         CMD_SWAP: begin
            if (cell_pos == cmd.pos_a) entry_in = cmd.data_b;
            else if (cell_pos == cmd.pos_b) entry_in = cmd.data_a;
         end
         default: entry_in = entry_ff;
      endcase
   end

   // only live entries may match
   assign hit_in = (entry_ff == look.key) && (CNT_W'(cell_pos) < look.count);

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;
   assign rd_a  = (cell_pos == look.sel_a) ? entry_ff : '0;
   assign rd_b  = (cell_pos == look.sel_b) ? entry_ff : '0;

endmodule

// ----- src/ole_ctrl.sv -----
// ----------------------------------------------------------------------------
// ole_ctrl: sequencer, count and result register of the list engine
// Latches an item, lets the cells compare, reduces the match bits in groups,
// then decides the action, issues one cell command and registers the result.
// ----------------------------------------------------------------------------
module ole_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [ole_pkg::REQ_W-1:0]  req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [ole_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic [ole_pkg::DEPTH-1:0]  hit,
   input  logic [ole_pkg::ITEM_W-1:0] rd_a [ole_pkg::DEPTH],
   input  logic [ole_pkg::ITEM_W-1:0] rd_b [ole_pkg::DEPTH],
   output ole_pkg::ole_look_type      look,
   output ole_pkg::ole_cmd_type       cmd
);
   import ole_pkg::*;

   ole_state_type     state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   ole_action_type    act_ff;
   logic [POS_W-1:0]  ia_ff, ib_ff;
   logic [ITEM_W-1:0] key_ff;

   logic [NGRP*GRP-1:0] hit_pad;
   logic              grp_any_ff [NGRP];
   logic              grp_any_in [NGRP];
   logic [GRP_W-1:0]  grp_idx_ff [NGRP];
   logic [GRP_W-1:0]  grp_idx_in [NGRP];

   logic [ITEM_W-1:0] rd_a_ff, rd_a_in, rd_b_ff, rd_b_in;

   logic [POS_W-1:0]  rindex_ff, rindex_in;
   logic [ITEM_W-1:0] rvalue_ff, rvalue_in;
   ole_status_type    status_ff, status_in;
   logic [CNT_W-1:0]  rcount_ff;

   logic              accept, fire, found;
   logic [IDX_W-1:0]  found_idx;
   logic              ia_ok, ib_ok, full;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // ---- group reduction of the match bits ----
   assign hit_pad = (NGRP*GRP)'(hit);

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g] = 1'b0;
         grp_idx_in[g] = '0;
         for (int k = GRP - 1; k >= 0; k--) begin
            if (hit_pad[g*GRP + k]) begin
               grp_any_in[g] = 1'b1;
               grp_idx_in[g] = GRP_W'(k);
            end
         end
      end
   end

   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            found     = 1'b1;
            found_idx = IDX_W'(g * GRP) + IDX_W'(grp_idx_ff[g]);
         end
      end
   end

   // ---- read buses ----
   always_comb begin
      rd_a_in = '0;
      rd_b_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_a_in = rd_a_in | rd_a[i];
         rd_b_in = rd_b_in | rd_b[i];
      end
   end

   always_comb begin
      look.key   = key_ff;
      look.count = count_ff;
      look.sel_b = IDX_W'(ib_ff);
      case (act_ff)
         ACT_LAST:     look.sel_a = IDX_W'(count_ff - 1'b1);
         ACT_EXCHANGE: look.sel_a = IDX_W'(ia_ff);
         default:      look.sel_a = '0;
      endcase
   end

   // ---- sequencer and action decode ----
   assign ia_ok = !ia_ff[POS_W-1] && (CNT_W'(ia_ff[POS_W-2:0]) < count_ff);
   assign ib_ok = !ib_ff[POS_W-1] && (CNT_W'(ib_ff[POS_W-2:0]) < count_ff);
   assign full  = (count_ff >= CNT_W'(DEPTH));
   assign fire  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      count_in     = count_ff;
      rindex_in    = '1;
      rvalue_in    = '0;
      status_in    = STAT_OK;
      cmd.kind     = CMD_HOLD;
      cmd.pos_a    = IDX_W'(ia_ff);
      cmd.pos_b    = IDX_W'(ib_ff);
      cmd.wvalue   = key_ff;
      cmd.data_a   = rd_a_ff;
      cmd.data_b   = rd_b_ff;

      case (act_ff)
         ACT_APPEND: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               cmd.kind  = CMD_WRITE;
               cmd.pos_a = IDX_W'(count_ff);
               rindex_in = POS_W'(count_ff);
               count_in  = count_ff + 1'b1;
            end
         end
         ACT_INSERT: begin
            if (ia_ff[POS_W-1]) begin
               status_in = STAT_BAD;
            end else if (full) begin
               status_in = STAT_FULL;
            end else if (!ia_ok) begin
               cmd.kind  = CMD_WRITE;
               cmd.pos_a = IDX_W'(count_ff);
               rindex_in = POS_W'(count_ff);
               count_in  = count_ff + 1'b1;
            end else begin
               cmd.kind  = CMD_INSERT;
               rindex_in = ia_ff;
               count_in  = count_ff + 1'b1;
            end
         end
         ACT_DELETE: begin
            if (!ia_ok) begin
               status_in = STAT_BAD;
            end else begin
               cmd.kind  = CMD_DROP;
               rindex_in = ia_ff;
               count_in  = count_ff - 1'b1;
            end
         end
         ACT_EXCHANGE: begin
            if (!ia_ok || !ib_ok || ia_ff == ib_ff) status_in = STAT_BAD;
            else cmd.kind = CMD_SWAP;
         end
         ACT_SEARCH: begin
            if (found) rindex_in = POS_W'(found_idx);
            else status_in = STAT_MISS;
         end
         ACT_REMOVE: begin
            if (found) begin
               cmd.kind  = CMD_DROP;
               cmd.pos_a = found_idx;
               rindex_in = POS_W'(found_idx);
               count_in  = count_ff - 1'b1;
            end else begin
               status_in = STAT_MISS;
            end
         end
         ACT_CLEAR: begin
            count_in = '0;
         end
         ACT_FIRST, ACT_LAST: begin
            if (count_ff == '0) status_in = STAT_BAD;
            else rvalue_in = rd_a_ff;
         end
         default: status_in = STAT_BAD;
      endcase

      // hold the list until the result slot is free
      if (!fire) begin
         cmd.kind = CMD_HOLD;
         count_in = count_ff;
      end

      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_LOOK;
         ST_LOOK:  state_in = ST_GROUP;
         ST_GROUP: state_in = ST_EXEC;
         ST_EXEC: begin
            if (fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= ole_action_type'(req_tdata[ACT_W-1:0]);
         ia_ff  <= req_tdata[ACT_W +: POS_W];
         ib_ff  <= req_tdata[ACT_W+POS_W +: POS_W];
         key_ff <= req_tdata[ACT_W+2*POS_W +: ITEM_W];
      end
      for (int g = 0; g < NGRP; g++) begin
         grp_any_ff[g] <= grp_any_in[g];
         grp_idx_ff[g] <= grp_idx_in[g];
      end
      rd_a_ff <= rd_a_in;
      rd_b_ff <= rd_b_in;
      if (fire) begin
         rindex_ff <= rindex_in;
         rvalue_ff <= rvalue_in;
         status_ff <= status_in;
         rcount_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rcount_ff, status_ff, rvalue_ff, rindex_ff});

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOOK)
      else $error("accepted item did not start the lookup");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("result raised outside execute");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      fire && status_in == STAT_FULL |-> count_ff == CNT_W'(DEPTH))
      else $error("full reported on a list with room");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC && !fire |=> $stable(count_ff))
      else $error("count moved while result stalled");
`endif

endmodule

// ----- src/ordered_item_list_engine.sv -----
// An accepted item passes the cell compare (lookup), the group reduction of the match
//   bits and the execute step, each registered; the result holds in execute while
//   rsp stalls. A new item is taken only after the last one's result is issued.
// Reset clears the entry count and the handshake state; the entry words are
//   not cleared and only entries below the count are ever read.
// ----------------------------------------------------------------------------
// ordered_item_list_engine: fixed-depth ordered word list
// A chain of cells holds the list; every cell shifts, loads or swaps its word
// on one broadcast command, and compares its word for search and remove.
// ----------------------------------------------------------------------------
module ordered_item_list_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // action[3:0], index_a[10:4], index_b[17:11], item_value[49:18], zero pad
   input  logic [ole_pkg::REQ_W-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // result_index[6:0], result_value[38:7], status[40:39], item_count[47:41]
   output logic [ole_pkg::RSP_W-1:0] rsp_tdata
);
   import ole_pkg::*;

   ole_look_type      look;
   ole_cmd_type       cmd;
   logic [ITEM_W-1:0] entry_w [DEPTH];
   logic [ITEM_W-1:0] rd_a_w  [DEPTH];
   logic [ITEM_W-1:0] rd_b_w  [DEPTH];
   logic [DEPTH-1:0]  hit_w;

   ole_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .hit        (hit_w),
      .rd_a       (rd_a_w),
      .rd_b       (rd_b_w),
      .look       (look),
      .cmd        (cmd)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ITEM_W-1:0] left_w, right_w;

      if (i == 0) begin : g_head
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = entry_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = entry_w[i+1];
      end

      ole_cell u_cell (
         .clock       (clock),
         .cell_pos    (IDX_W'(i)),
         .look        (look),
         .cmd         (cmd),
         .left_entry  (left_w),
         .right_entry (right_w),
         .entry       (entry_w[i]),
         .hit         (hit_w[i]),
         .rd_a        (rd_a_w[i]),
         .rd_b        (rd_b_w[i])
      );
   end

endmodule
